// ===== rtl/fkg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the fractional knapsack block.
// Used by fractional_knapsack_greedy and fkg_div; depends on nothing else.
package fkg_pkg;

    localparam int CAP_W     = 22;
    localparam int VAL_W     = 16;
    localparam int FRAC_W    = 17;
    localparam int TOTAL_W   = 48;
    localparam int INDEX_W   = 6;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic [VAL_W-1:0] profit;
        logic [VAL_W-1:0] weight;
        logic             is_last;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] item_index;
        logic [FRAC_W-1:0]  fraction;
        logic [TOTAL_W-1:0] total_profit;
        logic [CAP_W-1:0]   total_weight;
        logic               overflow;
        logic               last_result;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S_LDI,
        ST_S_LDW,
        ST_S_RD,
        ST_S_M1,
        ST_S_M2,
        ST_S_WR,
        ST_G_RD,
        ST_G_RK,
        ST_G_DEC,
        ST_G_DIV,
        ST_G_ACC,
        ST_O_RD,
        ST_O_EM
    } state_t;

endpackage

// ===== rtl/fractional_knapsack_greedy.sv =====
`timescale 1ns / 1ps
// Top level of the fractional knapsack: sequencer, shared multiplier, stores.
// Depends on fkg_pkg, fkg_ram and fkg_div.
//
//  channel  | signals                          | transfer when
//  ---------+----------------------------------+---------------------------
//  items    | start, busy, in_item             | start && !busy
//  config   | cfg_valid, cfg_ready, cfg_data   | cfg_valid && cfg_ready
//  results  | res_strobe, result               | every cycle res_strobe is high
//
// Loading accepts one item per cycle while busy is low. After the last item,
// ranking runs through one shared 17x16 multiplier, and in the greedy fill
// every item from the cut item on passes through the divider;
// the results then leave one by one through the fraction store port.
// busy is high for the whole run. Reset clears control state; the stores hold
// no reset value. The receiver cannot stall results.
module fractional_knapsack_greedy #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fkg_pkg::in_item_t             in_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fkg_pkg::CAP_W-1:0]     cfg_data,
    output logic                          res_strobe,
    output fkg_pkg::result_t              result
);

    import fkg_pkg::*;

    localparam int IDXW = $clog2(MAX_ITEMS);
    localparam int CNTW = $clog2(MAX_ITEMS + 1);

    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic                dropped_reg, dropped_next;
    logic [CNTW-1:0]     i_reg, i_next;
    logic [CNTW-1:0]     j_reg, j_next;
    logic [IDXW-1:0]     rank_reg, rank_next;
    logic [VAL_W-1:0]    pi_reg, pi_next;
    logic [VAL_W-1:0]    wi_reg, wi_next;
    logic [VAL_W-1:0]    wj_reg, wj_next;
    logic [2*VAL_W-1:0]  prod_reg, prod_next;
    logic [IDXW-1:0]     k_reg, k_next;
    logic [VAL_W-1:0]    pk_reg, pk_next;
    logic [FRAC_W-1:0]   f_reg, f_next;
    logic [CAP_W-1:0]    used_reg, used_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    result_t             res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic                pw_we;
    logic [IDXW-1:0]     pw_waddr, pw_raddr;
    logic [2*VAL_W-1:0]  pw_wdata, pw_rdata;
    logic                ord_we;
    logic [IDXW-1:0]     ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic                fr_we;
    logic [IDXW-1:0]     fr_waddr, fr_raddr;
    logic [FRAC_W-1:0]   fr_wdata, fr_rdata;

    logic [FRAC_W-1:0]   mul_a;
    logic [VAL_W-1:0]    mul_b;
    logic [FRAC_W+VAL_W-1:0] mul_p;

    logic                div_start, div_done;
    logic [VAL_W-1:0]    div_rem;
    logic [FRAC_W-1:0]   div_quot;

    logic [VAL_W-1:0]    w_fixed;
    logic [CAP_W:0]      fill_sum;
    logic                ranks_above;
    logic                fin;

    fkg_ram #(.WIDTH(2*VAL_W), .DEPTH(MAX_ITEMS)) u_pw_ram (
        .clk(clk), .we(pw_we), .waddr(pw_waddr), .wdata(pw_wdata),
        .raddr(pw_raddr), .rdata(pw_rdata)
    );

    fkg_ram #(.WIDTH(IDXW), .DEPTH(MAX_ITEMS)) u_ord_ram (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    fkg_ram #(.WIDTH(FRAC_W), .DEPTH(MAX_ITEMS)) u_fr_ram (
        .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .raddr(fr_raddr), .rdata(fr_rdata)
    );

    fkg_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .rem(div_rem),
        .divisor(pw_rdata[VAL_W-1:0]), .done(div_done), .quot(div_quot)
    );

    // The one multiplier serves both cross products and the profit total.
    assign mul_p = mul_a * mul_b;

    assign w_fixed     = (in_item.weight == '0) ? VAL_W'(1) : in_item.weight;
    assign fill_sum    = {1'b0, used_reg} + (CAP_W+1)'(pw_rdata[VAL_W-1:0]);
    assign ranks_above = (prod_reg > mul_p[2*VAL_W-1:0])
                      || ((prod_reg == mul_p[2*VAL_W-1:0]) && (j_reg < i_reg));
    assign fin         = (i_reg + 1'b1) == count_reg;

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        pi_next        = pi_reg;
        wi_next        = wi_reg;
        wj_next        = wj_reg;
        prod_next      = prod_reg;
        k_next         = k_reg;
        pk_next        = pk_reg;
        f_next         = f_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;

        pw_we     = 1'b0;
        pw_waddr  = count_reg[IDXW-1:0];
        pw_wdata  = {in_item.profit, w_fixed};
        pw_raddr  = i_reg[IDXW-1:0];
        ord_we    = 1'b0;
        ord_waddr = rank_reg;
        ord_wdata = i_reg[IDXW-1:0];
        ord_raddr = i_reg[IDXW-1:0];
        fr_we     = 1'b0;
        fr_waddr  = k_reg;
        fr_wdata  = f_reg;
        fr_raddr  = i_reg[IDXW-1:0];
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_rem   = '0;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < CNTW'(MAX_ITEMS))
                    begin
                        pw_we      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (in_item.is_last)
                    begin
                        i_next     = '0;
                        state_next = ST_S_LDI;
                    end
                end
            end
            ST_S_LDI:
            begin
                pw_raddr   = i_reg[IDXW-1:0];
                state_next = ST_S_LDW;
            end
            ST_S_LDW:
            begin
                pi_next    = pw_rdata[2*VAL_W-1:VAL_W];
                wi_next    = pw_rdata[VAL_W-1:0];
                j_next     = '0;
                rank_next  = '0;
                state_next = ST_S_RD;
            end
            ST_S_RD:
            begin
                pw_raddr   = j_reg[IDXW-1:0];
                state_next = ST_S_M1;
            end
            ST_S_M1:
            begin
                mul_a      = {1'b0, pw_rdata[2*VAL_W-1:VAL_W]};
                mul_b      = wi_reg;
                prod_next  = mul_p[2*VAL_W-1:0];
                wj_next    = pw_rdata[VAL_W-1:0];
                state_next = ST_S_M2;
            end
            ST_S_M2:
            begin
                // Item j outranks item i on a higher ratio, or an equal one
                // with earlier arrival; the count of those is i's rank.
                mul_a = {1'b0, pi_reg};
                mul_b = wj_reg;
                if (ranks_above)
                begin
                    rank_next = rank_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
                if ((j_reg + 1'b1) == count_reg)
                begin
                    state_next = ST_S_WR;
                end
                else
                begin
                    state_next = ST_S_RD;
                end
            end
            ST_S_WR:
            begin
                ord_we = 1'b1;
                i_next = i_reg + 1'b1;
                if (fin)
                begin
                    i_next     = '0;
                    used_next  = '0;
                    total_next = '0;
                    state_next = ST_G_RD;
                end
                else
                begin
                    state_next = ST_S_LDI;
                end
            end
            ST_G_RD:
            begin
                ord_raddr  = i_reg[IDXW-1:0];
                state_next = ST_G_RK;
            end
            ST_G_RK:
            begin
                k_next     = ord_rdata;
                pw_raddr   = ord_rdata;
                state_next = ST_G_DEC;
            end
            ST_G_DEC:
            begin
                pk_next = pw_rdata[2*VAL_W-1:VAL_W];
                if (fill_sum < {1'b0, cap_reg})
                begin
                    f_next     = FRAC_ONE;
                    used_next  = fill_sum[CAP_W-1:0];
                    state_next = ST_G_ACC;
                end
                else
                begin
                    // The room left never exceeds this item's weight.
                    div_start = 1'b1;
                    if (cap_reg > used_reg)
                    begin
                        div_rem = VAL_W'(cap_reg - used_reg);
                    end
                    used_next  = cap_reg;
                    state_next = ST_G_DIV;
                end
            end
            ST_G_DIV:
            begin
                if (div_done)
                begin
                    f_next     = div_quot;
                    state_next = ST_G_ACC;
                end
            end
            ST_G_ACC:
            begin
                mul_a      = f_reg;
                mul_b      = pk_reg;
                total_next = total_reg + TOTAL_W'(mul_p);
                fr_we      = 1'b1;
                i_next     = i_reg + 1'b1;
                if (fin)
                begin
                    i_next     = '0;
                    state_next = ST_O_RD;
                end
                else
                begin
                    state_next = ST_G_RD;
                end
            end
            ST_O_RD:
            begin
                fr_raddr   = i_reg[IDXW-1:0];
                state_next = ST_O_EM;
            end
            ST_O_EM:
            begin
                res_valid_next        = 1'b1;
                res_next.item_index   = INDEX_W'(i_reg);
                res_next.fraction     = fr_rdata;
                res_next.total_profit = fin ? total_reg : '0;
                res_next.total_weight = fin ? used_reg : '0;
                res_next.overflow     = dropped_reg;
                res_next.last_result  = fin;
                i_next                = i_reg + 1'b1;
                if (fin)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_O_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            used_reg      <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rank_reg      <= rank_next;
            used_reg      <= used_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg   <= pi_next;
        wi_reg   <= wi_next;
        wj_reg   <= wj_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        pk_reg   <= pk_next;
        f_reg    <= f_next;
        res_reg  <= res_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign res_strobe = res_valid_reg;
    assign result     = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_ITEMS))
        else $error("stored item count exceeds the store depth");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G_ACC) |-> (used_reg <= cap_reg))
        else $error("used weight exceeds capacity during the fill");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_G_DIV))
        else $error("divider finished outside the cut step");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G_ACC) |-> (f_reg <= FRAC_ONE))
        else $error("fraction above one whole item");

    a_totals_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && !result.last_result) |->
            (result.total_profit == '0 && result.total_weight == '0))
        else $error("totals present on a result that is not the last");

endmodule

// ===== rtl/fkg_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing else.
module fkg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fkg_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: floor(rem * 65536 / divisor), rem <= divisor.
// Uses fkg_pkg for widths.
module fkg_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fkg_pkg::VAL_W-1:0]    rem,
    input  logic [fkg_pkg::VAL_W-1:0]    divisor,
    output logic                         done,
    output logic [fkg_pkg::FRAC_W-1:0]   quot
);

    import fkg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [VAL_W-1:0]     acc_reg, acc_next;
    logic [2*VAL_W-1:0]   dq_reg, dq_next;
    logic [VAL_W-1:0]     div_reg, div_next;
    logic [VAL_W:0]       trial;
    logic                 fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        trial     = {acc_reg, dq_reg[2*VAL_W-1]};
        fits      = trial >= {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            dq_next   = {rem, {VAL_W{1'b0}}};
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so one bit fits.
            acc_next = fits ? VAL_W'(trial - {1'b0, div_reg}) : trial[VAL_W-1:0];
            dq_next  = {dq_reg[2*VAL_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            dq_reg   <= '0;
            div_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            dq_reg   <= dq_next;
            div_reg  <= div_next;
        end
    end

    assign done = done_reg;
    assign quot = dq_reg[FRAC_W-1:0];

endmodule
